// ----- rtl/tkucs_pkg.sv -----
`timescale 1ns / 1ps

package tkucs_pkg;

	localparam int MAX_SELECT_DEF = 16;

	localparam int DIST_W  = 32;
	localparam int INDEX_W = 16;
	localparam int LIMIT_W = 5;
	localparam int CFG_IDX_W = 2;

	// register map
	localparam logic [CFG_IDX_W-1:0] REG_FRUSTUM_ONLY   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DEFER_ENABLE   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DEFER_DISTANCE = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SELECT_LIMIT   = 2'd3;

	localparam logic [DIST_W-1:0]  DEFER_DISTANCE_RST = 32'd65536;
	localparam logic [LIMIT_W-1:0] SELECT_LIMIT_RST   = 5'd16;

	typedef struct packed {
		logic [INDEX_W-1:0] index;
		logic               active;
		logic               in_frustum;
		logic [DIST_W-1:0]  distance;
	} cand_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INS_CMP,
		ST_INS_PUT,
		ST_FIN_RD,
		ST_FIN_LD,
		ST_FIN_NONE
	} state_t;

	// a strictly ahead of b: active, then visible, then nearer, then lower index
	function automatic logic ranks_before(input cand_t a, input cand_t b);
		logic r;
		if (a.active != b.active) begin
			r = a.active;
		end else if (a.in_frustum != b.in_frustum) begin
			r = a.in_frustum;
		end else if (a.distance != b.distance) begin
			r = a.distance < b.distance;
		end else begin
			r = a.index < b.index;
		end
		return r;
	endfunction

endpackage

// ----- rtl/top_k_update_candidate_selector_unit.sv -----
`timescale 1ns / 1ps
// Candidate item: accepted, then one table entry per cycle walked from the tail, as set by
//   the single compare unit and the single table read port; the input stalls meanwhile.
// Finish item: each emitted result takes a RAM read, then an output load, which waits out
//   any output stall; an empty table gives one result.
// Reset (arst_n low, asynchronous): table empty, registers 0, 1, 65536, 16; table RAM
//   contents are not cleared and are never read before being written.
module top_k_update_candidate_selector_unit #(
	parameter int MAX_SELECT = tkucs_pkg::MAX_SELECT_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// config write channel
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [tkucs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [tkucs_pkg::DIST_W-1:0]    cfg_data,
	// input items
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            kind,
	input  logic                            needs_update,
	input  logic                            active,
	input  logic                            in_frustum,
	input  logic                            has_published,
	input  logic                            population_pending,
	input  logic [tkucs_pkg::DIST_W-1:0]    distance,
	input  logic [tkucs_pkg::INDEX_W-1:0]   chunk_index,
	// result items
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [tkucs_pkg::INDEX_W-1:0]   sel_index,
	output logic                            sel_active,
	output logic                            sel_in_frustum,
	output logic [tkucs_pkg::DIST_W-1:0]    sel_distance,
	output logic                            none,
	output logic                            last
);
	import tkucs_pkg::*;

	// CW holds a count 0..MAX_SELECT, AW addresses the table
	localparam int CW = $clog2(MAX_SELECT + 1);
	localparam int AW = (MAX_SELECT > 1) ? $clog2(MAX_SELECT) : 1;
	localparam int LW = (CW > LIMIT_W) ? CW : LIMIT_W;

	// configuration registers
	logic              frustum_only_q;
	logic              defer_enable_q;
	logic [DIST_W-1:0] defer_distance_q;
	logic [LIMIT_W-1:0] select_limit_q;

	state_t state_q, state_d;

	logic [CW-1:0] cnt_q;    // entries held in the table
	logic [CW-1:0] pos_q;    // hole position while inserting
	logic [CW-1:0] k_q;      // emit pointer
	logic [CW-1:0] n_q;      // entries to emit
	cand_t         cand_q;   // candidate being inserted

	// table RAM, one write and one registered read per cycle
	cand_t   mem [MAX_SELECT];
	cand_t   rd_data_q;
	logic    rd_en, wr_en;
	logic [AW-1:0] rd_addr, wr_addr;
	cand_t   wr_data;

	// output register
	logic              out_valid_q;
	logic [INDEX_W-1:0] sel_index_q;
	logic              sel_active_q, sel_in_frustum_q, none_q, last_q;
	logic [DIST_W-1:0] sel_distance_q;
	logic              out_free, out_load, none_load;

	logic [LW-1:0] lim_ext;
	logic [CW-1:0] lim, n;
	logic          accept_in, keep, ahead, last_hit;
	cand_t         cand_in;
	logic [CW-1:0] n_m1, pos_m1, pos_m2;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != ST_IDLE);
	assign accept_in = in_valid && !in_stall;

	// effective limit: select_limit clipped to the table size
	assign lim_ext = (LW'(select_limit_q) > LW'(MAX_SELECT)) ? LW'(MAX_SELECT)
	                                                          : LW'(select_limit_q);
	assign lim = lim_ext[CW-1:0];
	assign n   = (cnt_q > lim) ? lim : cnt_q;

	// drop filter
	assign keep = needs_update
	              && !(frustum_only_q && !in_frustum && !active)
	              && !(defer_enable_q && !active && has_published && population_pending
	                   && (distance > defer_distance_q));

	assign cand_in = '{index: chunk_index, active: active, in_frustum: in_frustum,
	                   distance: distance};

	// the shared compare unit: new candidate against the entry just read
	assign ahead    = ranks_before(cand_q, rd_data_q);
	assign last_hit = ((k_q + 1'b1) == n_q);
	assign out_free = !out_valid_q || !out_stall;

	assign n_m1   = n - 1'b1;
	assign pos_m1 = pos_q - 1'b1;
	assign pos_m2 = pos_q - CW'(2);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frustum_only_q   <= 1'b0;
			defer_enable_q   <= 1'b1;
			defer_distance_q <= DEFER_DISTANCE_RST;
			select_limit_q   <= SELECT_LIMIT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_FRUSTUM_ONLY:   frustum_only_q   <= cfg_data[0];
				REG_DEFER_ENABLE:   defer_enable_q   <= cfg_data[0];
				REG_DEFER_DISTANCE: defer_distance_q <= cfg_data;
				REG_SELECT_LIMIT:   select_limit_q   <= cfg_data[LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept_in) begin
					if (kind) begin
						state_d = (n == '0) ? ST_FIN_NONE : ST_FIN_RD;
					end else if (keep) begin
						state_d = (n == '0) ? ST_INS_PUT : ST_INS_CMP;
					end
				end
			end
			ST_INS_CMP: begin
				if (ahead) begin
					if (pos_q == CW'(1)) state_d = ST_INS_PUT;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_INS_PUT:  state_d = ST_IDLE;
			ST_FIN_RD:   state_d = ST_FIN_LD;
			ST_FIN_LD: begin
				if (out_free) state_d = last_hit ? ST_IDLE : ST_FIN_RD;
			end
			ST_FIN_NONE: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// datapath controls
	always_comb begin
		rd_en     = 1'b0;
		rd_addr   = '0;
		wr_en     = 1'b0;
		wr_addr   = pos_q[AW-1:0];
		wr_data   = cand_q;
		out_load  = 1'b0;
		none_load = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept_in && !kind && keep && (n != '0)) begin
					rd_en   = 1'b1;
					rd_addr = n_m1[AW-1:0];
				end
			end
			ST_INS_CMP: begin
				// pushing an entry to pos drops it when pos is at or past the limit
				wr_en = (pos_q < lim);
				if (ahead) begin
					wr_data = rd_data_q;
					if (pos_q > CW'(1)) begin
						rd_en   = 1'b1;
						rd_addr = pos_m2[AW-1:0];
					end
				end
			end
			ST_INS_PUT: wr_en = (pos_q < lim);
			ST_FIN_RD: begin
				rd_en   = 1'b1;
				rd_addr = k_q[AW-1:0];
			end
			ST_FIN_LD:   out_load  = out_free;
			ST_FIN_NONE: none_load = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (accept_in && kind) begin
				cnt_q <= '0;
			end else if (accept_in && keep) begin
				cnt_q <= (n < lim) ? (n + 1'b1) : n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept_in) begin
			cand_q <= cand_in;
			pos_q  <= n;
			n_q    <= n;
			k_q    <= '0;
		end else begin
			if ((state_q == ST_INS_CMP) && ahead) pos_q <= pos_m1;
			if (out_load) k_q <= k_q + 1'b1;
		end
	end

	// table RAM
	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
	end

	always_ff @(posedge clk) begin
		if (rd_en) rd_data_q <= mem[rd_addr];
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load || none_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			sel_index_q      <= rd_data_q.index;
			sel_active_q     <= rd_data_q.active;
			sel_in_frustum_q <= rd_data_q.in_frustum;
			sel_distance_q   <= rd_data_q.distance;
			none_q           <= 1'b0;
			last_q           <= last_hit;
		end else if (none_load) begin
			sel_index_q      <= '0;
			sel_active_q     <= 1'b0;
			sel_in_frustum_q <= 1'b0;
			sel_distance_q   <= '0;
			none_q           <= 1'b1;
			last_q           <= 1'b1;
		end
	end

	assign out_valid      = out_valid_q;
	assign sel_index      = sel_index_q;
	assign sel_active     = sel_active_q;
	assign sel_in_frustum = sel_in_frustum_q;
	assign sel_distance   = sel_distance_q;
	assign none           = none_q;
	assign last           = last_q;

	// checks
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(MAX_SELECT))
		else $error("table count above capacity");

	a_finish_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(accept_in && kind) |=> (cnt_q == '0))
		else $error("finish did not clear the table");

	a_none_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && none_q) |-> last_q)
		else $error("empty result not marked last");

	a_cmp_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_INS_CMP) |-> (pos_q != '0))
		else $error("compare with no entry above the hole");

endmodule

// ----- tb/tkucs_tb_pkg.sv -----
`timescale 1ns / 1ps

package tkucs_tb_pkg;

	// item kinds on the input channel
	localparam logic KIND_CANDIDATE = 1'b0;
	localparam logic KIND_FINISH    = 1'b1;

endpackage

// ----- tb/tkucs_checker.sv -----
`timescale 1ns / 1ps

module tkucs_checker #(
	parameter int MAX_SELECT = tkucs_pkg::MAX_SELECT_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	input  logic                            cfg_ready,
	input  logic [tkucs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [tkucs_pkg::DIST_W-1:0]    cfg_data,
	input  logic                            in_valid,
	input  logic                            in_stall,
	input  logic                            kind,
	input  logic                            needs_update,
	input  logic                            active,
	input  logic                            in_frustum,
	input  logic                            has_published,
	input  logic                            population_pending,
	input  logic [tkucs_pkg::DIST_W-1:0]    distance,
	input  logic [tkucs_pkg::INDEX_W-1:0]   chunk_index,
	input  logic                            out_valid,
	input  logic                            out_stall,
	input  logic [tkucs_pkg::INDEX_W-1:0]   sel_index,
	input  logic                            sel_active,
	input  logic                            sel_in_frustum,
	input  logic [tkucs_pkg::DIST_W-1:0]    sel_distance,
	input  logic                            none,
	input  logic                            last,
	output int                              err_count,
	output int                              pending
);

	import tkucs_pkg::*;
	import tkucs_tb_pkg::*;

	typedef struct packed {
		logic [INDEX_W-1:0] index;
		logic               active;
		logic               in_frustum;
		logic [DIST_W-1:0]  distance;
		logic               none;
		logic               last;
	} sel_item_t;

	logic               frustum_only_q;
	logic               defer_en_q;
	logic [DIST_W-1:0]  defer_dist_q;
	logic [LIMIT_W-1:0] limit_q;

	cand_t       best_q [MAX_SELECT];
	int unsigned best_cnt;
	sel_item_t   sel_expected [$];
	int          errors = 0;
	int          waiting = 0;

	assign err_count = errors;
	assign pending   = waiting;

	function automatic int unsigned kept_limit();
		return (limit_q > MAX_SELECT) ? MAX_SELECT : limit_q;
	endfunction

	function automatic bit outranks(cand_t a, cand_t b);
		if (a.active != b.active)
			return a.active;
		if (a.in_frustum != b.in_frustum)
			return a.in_frustum;
		if (a.distance != b.distance)
			return a.distance < b.distance;
		return a.index < b.index;
	endfunction

	// sorted insert; later arrivals go behind equal entries
	task automatic keep_candidate(cand_t c);
		int unsigned lim;
		int unsigned n;
		int unsigned pos;
		lim = kept_limit();
		n   = (best_cnt > lim) ? lim : best_cnt;
		pos = 0;
		while (pos < n && !outranks(c, best_q[pos]))
			pos++;
		if (pos >= lim) begin
			best_cnt = n;
		end else begin
			if (n >= lim)
				n = lim - 1;
			for (int unsigned i = n; i > pos; i--)
				best_q[i] = best_q[i-1];
			best_q[pos] = c;
			best_cnt = n + 1;
		end
	endtask

	task automatic emit_selection();
		int unsigned lim;
		int unsigned n;
		sel_item_t   r;
		lim = kept_limit();
		n   = (best_cnt > lim) ? lim : best_cnt;
		best_cnt = 0;
		if (n == 0) begin
			r = '0;
			r.none = 1'b1;
			r.last = 1'b1;
			sel_expected = {sel_expected, r};
		end else begin
			for (int unsigned k = 0; k < n; k++) begin
				r.index      = best_q[k].index;
				r.active     = best_q[k].active;
				r.in_frustum = best_q[k].in_frustum;
				r.distance   = best_q[k].distance;
				r.none       = 1'b0;
				r.last       = (k + 1 == n);
				sel_expected = {sel_expected, r};
			end
		end
	endtask

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %h actual %h", $time, name, want, got);
			errors++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		sel_item_t want;
		cand_t     c;
		if (!arst_n) begin
			frustum_only_q = 1'b0;
			defer_en_q     = 1'b1;
			defer_dist_q   = DEFER_DISTANCE_RST;
			limit_q        = SELECT_LIMIT_RST;
			best_cnt       = 0;
			sel_expected.delete();
		end else begin
			if (out_valid && !out_stall) begin
				if (sel_expected.size() == 0) begin
					$display("%0t: result expected none actual index %h none %b last %b",
						$time, sel_index, none, last);
					errors++;
				end else begin
					want = sel_expected.pop_front();
					check_field("sel_index", 32'(want.index), 32'(sel_index));
					check_field("sel_active", 32'(want.active), 32'(sel_active));
					check_field("sel_in_frustum", 32'(want.in_frustum), 32'(sel_in_frustum));
					check_field("sel_distance", want.distance, sel_distance);
					check_field("none", 32'(want.none), 32'(none));
					check_field("last", 32'(want.last), 32'(last));
				end
			end
			// an item taken at this edge still sees the old register values
			if (in_valid && !in_stall) begin
				if (kind == KIND_FINISH) begin
					emit_selection();
				end else if (needs_update
						&& !(frustum_only_q && !in_frustum && !active)
						&& !(defer_en_q && !active && has_published && population_pending
							&& distance > defer_dist_q)) begin
					c.index      = chunk_index;
					c.active     = active;
					c.in_frustum = in_frustum;
					c.distance   = distance;
					keep_candidate(c);
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_FRUSTUM_ONLY: frustum_only_q = cfg_data[0];
					REG_DEFER_ENABLE: defer_en_q = cfg_data[0];
					REG_DEFER_DISTANCE: defer_dist_q = cfg_data;
					REG_SELECT_LIMIT: limit_q = cfg_data[LIMIT_W-1:0];
					default: ;
				endcase
			end
		end
		waiting = sel_expected.size();
	end

endmodule

// ----- tb/tb_top_k_update_candidate_selector_unit.sv -----
`timescale 1ns / 1ps

module tb_top_k_update_candidate_selector_unit;

	import tkucs_pkg::*;
	import tkucs_tb_pkg::*;

	localparam int MAX_SELECT  = MAX_SELECT_DEF;
	// a candidate may still be walking the table after the last result: allow for it
	localparam int SETTLE      = MAX_SELECT + 4;
	localparam int CYCLE_LIMIT = 300000;
	localparam int RAND_ITEMS  = 76;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [DIST_W-1:0]    cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic                 kind = KIND_CANDIDATE;
	logic                 needs_update = 1'b0;
	logic                 active = 1'b0;
	logic                 in_frustum = 1'b0;
	logic                 has_published = 1'b0;
	logic                 population_pending = 1'b0;
	logic [DIST_W-1:0]    distance = '0;
	logic [INDEX_W-1:0]   chunk_index = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [INDEX_W-1:0]   sel_index;
	logic                 sel_active;
	logic                 sel_in_frustum;
	logic [DIST_W-1:0]    sel_distance;
	logic                 none;
	logic                 last;

	int                   err_count;
	int                   pending;
	int                   cycles = 0;
	// no idling on either side while set
	bit                   calm = 1'b0;
	// threshold currently programmed, to aim distances at it
	logic [DIST_W-1:0]    cur_defer_dist = DEFER_DISTANCE_RST;

	always #5 clk = ~clk;

	top_k_update_candidate_selector_unit #(
		.MAX_SELECT(MAX_SELECT)
	) dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.kind(kind), .needs_update(needs_update), .active(active),
		.in_frustum(in_frustum), .has_published(has_published),
		.population_pending(population_pending),
		.distance(distance), .chunk_index(chunk_index),
		.out_valid(out_valid), .out_stall(out_stall),
		.sel_index(sel_index), .sel_active(sel_active),
		.sel_in_frustum(sel_in_frustum), .sel_distance(sel_distance),
		.none(none), .last(last)
	);

	tkucs_checker #(
		.MAX_SELECT(MAX_SELECT)
	) u_checker (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.kind(kind), .needs_update(needs_update), .active(active),
		.in_frustum(in_frustum), .has_published(has_published),
		.population_pending(population_pending),
		.distance(distance), .chunk_index(chunk_index),
		.out_valid(out_valid), .out_stall(out_stall),
		.sel_index(sel_index), .sel_active(sel_active),
		.sel_in_frustum(sel_in_frustum), .sel_distance(sel_distance),
		.none(none), .last(last),
		.err_count(err_count), .pending(pending)
	);

	// receiver back-pressure, stalling with a probability of about 14 percent outside the calm stretch
	always @(posedge clk) begin
		out_stall <= !calm && ($urandom_range(0, 99) < 14);
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("top_k_update_candidate_selector_unit test failed");
			$finish;
		end
	end

	// present one item and hold it until taken; valid stays high on return so that
	// a following item goes out back to back
	task automatic push_item(input logic k, input logic nu, input logic ac, input logic vis,
			input logic pub, input logic pop, input logic [DIST_W-1:0] d,
			input logic [INDEX_W-1:0] idx);
		int gap;
		gap = 0;
		if (!calm)
			while ($urandom_range(0, 99) < 14)
				gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid           <= 1'b1;
		kind               <= k;
		needs_update       <= nu;
		active             <= ac;
		in_frustum         <= vis;
		has_published      <= pub;
		population_pending <= pop;
		distance           <= d;
		chunk_index        <= idx;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic push_cand(input logic nu, input logic ac, input logic vis, input logic pub,
			input logic pop, input logic [DIST_W-1:0] d, input logic [INDEX_W-1:0] idx);
		push_item(KIND_CANDIDATE, nu, ac, vis, pub, pop, d, idx);
	endtask

	// the other fields of a finish item are don't-care; toggle them anyway
	task automatic push_finish();
		push_item(KIND_FINISH, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
			1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
			$urandom, 16'($urandom_range(0, 65535)));
	endtask

	// stop sending, let every result drain, then let any table walk finish
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIST_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == REG_DEFER_DISTANCE)
			cur_defer_dist = data;
		@(posedge clk);
	endtask

	task automatic random_config();
		logic [DIST_W-1:0] dd;
		logic [DIST_W-1:0] lim;
		case ($urandom_range(0, 3))
			0: dd = $urandom;
			1: dd = '0;
			2: dd = '1;
			default: dd = $urandom_range(0, 1000);
		endcase
		// upper data bits are ignored by the limit register but still toggled
		lim = $urandom;
		case ($urandom_range(0, 3))
			0: lim[LIMIT_W-1:0] = LIMIT_W'($urandom_range(0, 31));
			1: lim[LIMIT_W-1:0] = LIMIT_W'($urandom_range(1, 4));
			2: lim[LIMIT_W-1:0] = LIMIT_W'(MAX_SELECT);
			default: lim[LIMIT_W-1:0] = LIMIT_W'($urandom_range(0, 2));
		endcase
		write_reg(REG_FRUSTUM_ONLY, $urandom);
		write_reg(REG_DEFER_ENABLE, $urandom);
		write_reg(REG_DEFER_DISTANCE, dd);
		write_reg(REG_SELECT_LIMIT, lim);
	endtask

	// mostly items that survive the filter, with the odd one that does not
	task automatic random_cand();
		logic              nu;
		logic [DIST_W-1:0] d;
		logic [INDEX_W-1:0] idx;
		nu = ($urandom_range(0, 99) < 88);
		case ($urandom_range(0, 3))
			0: d = $urandom;
			1: d = cur_defer_dist + $urandom_range(0, 2) - 1;
			2: d = $urandom_range(0, 255);
			default: d = $urandom_range(0, 1) ? '1 : '0;
		endcase
		// small indices give plenty of ties on the last key
		idx = $urandom_range(0, 1) ? 16'($urandom_range(0, 65535)) : 16'($urandom_range(0, 7));
		push_cand(nu, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
			1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), d, idx);
	endtask

	initial begin
		int  sent;
		int  n_cand;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// --- directed, reset settings: frustum off, deferral on at 65536, limit 16 ---
		push_finish();                                          // empty table
		push_cand(1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 32'd10, 16'd1); // needs no update
		push_cand(1'b1, 1'b1, 1'b0, 1'b1, 1'b1, '1, 16'hFFFF);  // active beats deferral
		push_cand(1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 32'd65537, 16'd2); // deferred
		push_cand(1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 32'd65536, 16'd3); // at threshold, kept
		push_cand(1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 32'd0, 16'd0);
		push_cand(1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 32'hFFFF_0000, 16'd4); // no population
		push_cand(1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 32'hFFFF_0000, 16'd5); // not published
		push_cand(1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 32'd100, 16'd7);  // full tie pair
		push_cand(1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 32'd100, 16'd7);
		push_cand(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 32'd9, 16'd8);    // unseen, still kept
		push_finish();
		drain();

		// frustum only, deferral off, limit below the survivors
		write_reg(REG_FRUSTUM_ONLY, 32'd1);
		write_reg(REG_DEFER_ENABLE, 32'd0);
		write_reg(REG_DEFER_DISTANCE, 32'd0);
		write_reg(REG_SELECT_LIMIT, 32'd2);
		push_cand(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 32'd1, 16'd20);   // dropped, unseen
		push_cand(1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 32'd5, 16'd21);
		push_cand(1'b1, 1'b1, 1'b0, 1'b1, 1'b1, '1, 16'd22);
		push_cand(1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 32'd1, 16'd23);   // kept, deferral off
		push_finish();
		drain();

		// limit zero keeps nothing
		write_reg(REG_SELECT_LIMIT, 32'd0);
		push_cand(1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 32'd3, 16'd30);
		push_finish();
		drain();

		// limit above capacity, then lowered while collecting
		write_reg(REG_FRUSTUM_ONLY, 32'd0);
		write_reg(REG_DEFER_ENABLE, 32'd1);
		write_reg(REG_DEFER_DISTANCE, '1);
		write_reg(REG_SELECT_LIMIT, 32'd31);
		push_cand(1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 32'd40, 16'd40);
		push_cand(1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 32'd41, 16'd41);
		push_cand(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 32'd42, 16'd42);
		drain();
		write_reg(REG_SELECT_LIMIT, 32'd1);
		push_cand(1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 32'd43, 16'd43);
		push_finish();
		drain();

		// --- random: batches of candidates closed by a finish ---
		sent = 0;
		while (sent < RAND_ITEMS) begin
			// each batch starts from an idle block, so the sender waits out
			// every result of the previous one here
			drain();
			calm = (sent >= 40 && sent < 70);
			if ($urandom_range(0, 99) < 60)
				random_config();
			n_cand = ($urandom_range(0, 9) == 0) ? $urandom_range(MAX_SELECT, MAX_SELECT + 4)
				: $urandom_range(0, 8);
			for (int i = 0; i < n_cand; i++) begin
				// now and then the limit moves while the table is part filled
				if (i == n_cand / 2 && $urandom_range(0, 9) == 0) begin
					drain();
					write_reg(REG_SELECT_LIMIT, $urandom_range(0, 31));
				end
				random_cand();
				sent++;
			end
			push_finish();
			sent++;
		end
		drain();

		if (err_count == 0) begin
			$display("top_k_update_candidate_selector_unit test passed");
		end else begin
			$display("top_k_update_candidate_selector_unit test failed");
		end
		$finish;
	end

endmodule
